@@ rtl/core/lps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the line pixel stepper.
package lps_pkg;

   // Default geometry
   localparam int ROW_PITCH_DEFAULT  = 512;
   localparam int COORD_BITS_DEFAULT = 9;

   // Fixed field widths
   localparam int FIELD_COORD_BITS = 9;
   localparam int INDEX_BITS       = 18;
   localparam int COLOR_BITS       = 16;
   localparam int ERROR_BITS       = 10;

   // Transaction kinds on the request channel
   typedef enum logic {
      KIND_START = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic [FIELD_COORD_BITS-1:0] start_x;
      logic [FIELD_COORD_BITS-1:0] start_y;
      logic [FIELD_COORD_BITS-1:0] end_x;
      logic [FIELD_COORD_BITS-1:0] end_y;
      logic [COLOR_BITS-1:0]       line_color;
   } req_type;

   typedef struct packed {
      logic [FIELD_COORD_BITS-1:0] pixel_x;
      logic [FIELD_COORD_BITS-1:0] pixel_y;
      logic [INDEX_BITS-1:0]       pixel_index;
      logic [COLOR_BITS-1:0]       pixel_value;
      logic                        last_pixel;
   } rsp_type;

endpackage

@@ rtl/core/lps_in_reg.sv @@
`timescale 1ns / 1ps
// Input register of the line pixel stepper: holds one request transaction.
module lps_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lps_pkg::req_type req_payload,
   input  logic             out_ready,
   output logic             item_valid,
   output lps_pkg::req_type item
);

   logic             valid_ff, valid_in;
   lps_pkg::req_type item_ff, item_in;
   logic             load;
   logic             drain;

   // Drain the held transaction whenever the result side can take it
   assign drain     = valid_ff && out_ready;
   assign req_stall = valid_ff && !out_ready;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_payload;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/core/lps_stepper.sv @@
`timescale 1ns / 1ps
// Line state and per-pixel stepping datapath of the line pixel stepper.
module lps_stepper #(
   parameter int ROW_PITCH  = lps_pkg::ROW_PITCH_DEFAULT,
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  lps_pkg::req_type item,
   output logic             emit,
   output lps_pkg::rsp_type pixel
);

   localparam int CB    = COORD_BITS;
   localparam int EB    = lps_pkg::ERROR_BITS;
   localparam int SW    = ((EB > CB) ? EB : CB) + 1;
   localparam int PB    = $clog2(ROW_PITCH + 1);
   localparam int IW    = CB + PB + 1;

   // Line state
   logic [CB-1:0]                 cur_x_ff, cur_x_in;
   logic [CB-1:0]                 cur_y_ff, cur_y_in;
   logic                          x_neg_ff, x_neg_in;
   logic                          y_neg_ff, y_neg_in;
   logic                          x_major_ff, x_major_in;
   logic [CB-1:0]                 major_ff, major_in;
   logic [CB-1:0]                 minor_ff, minor_in;
   logic [EB-1:0]                 error_ff, error_in;
   logic [CB:0]                   left_ff, left_in;
   logic [lps_pkg::COLOR_BITS-1:0] color_ff, color_in;
   logic                          busy_ff, busy_in;

   // Start decode
   logic [CB-1:0] sx, sy, ex, ey;
   logic          s_x_neg, s_y_neg, s_x_major;
   logic [CB-1:0] adx, ady, s_major, s_minor;

   // Tick datapath
   logic [CB-1:0] x_stepped, y_stepped;
   logic [SW-1:0] err_sum;
   logic          minor_step;
   logic [CB:0]   left_next;
   logic [IW-1:0] index_wide;
   logic          is_start, is_tick;

   assign is_start = fire && (item.kind == lps_pkg::KIND_START);
   assign is_tick  = fire && (item.kind == lps_pkg::KIND_TICK) && busy_ff;

   // Take endpoints modulo the coordinate range and find the deltas
   assign sx        = CB'(item.start_x);
   assign sy        = CB'(item.start_y);
   assign ex        = CB'(item.end_x);
   assign ey        = CB'(item.end_y);
   assign s_x_neg   = ex < sx;
   assign s_y_neg   = ey < sy;
   assign adx       = s_x_neg ? sx - ex : ex - sx;
   assign ady       = s_y_neg ? sy - ey : ey - sy;
   assign s_x_major = adx > ady;
   assign s_major   = s_x_major ? adx : ady;
   assign s_minor   = s_x_major ? ady : adx;

   // Step both axes one pixel; the error decides whether the minor axis moves
   assign x_stepped  = x_neg_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
   assign y_stepped  = y_neg_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);
   assign err_sum    = SW'(error_ff) + SW'(minor_ff);
   assign minor_step = err_sum >= SW'(major_ff);
   assign left_next  = left_ff - (CB + 1)'(1);

   // Form the framebuffer index from the current position
   assign index_wide = IW'(cur_y_ff) * IW'(ROW_PITCH) + IW'(cur_x_ff);

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      x_major_in = x_major_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      error_in   = error_ff;
      left_in    = left_ff;
      color_in   = color_ff;
      busy_in    = busy_ff;
      if (is_start) begin
         cur_x_in   = sx;
         cur_y_in   = sy;
         x_neg_in   = s_x_neg;
         y_neg_in   = s_y_neg;
         x_major_in = s_x_major;
         major_in   = s_major;
         minor_in   = s_minor;
         error_in   = '0;
         left_in    = {1'b0, s_major} + (CB + 1)'(1);
         color_in   = item.line_color;
         busy_in    = 1'b1;
      end else if (is_tick) begin
         if (x_major_ff || minor_step) begin
            cur_x_in = x_stepped;
         end
         if (!x_major_ff || minor_step) begin
            cur_y_in = y_stepped;
         end
         error_in = EB'(minor_step ? err_sum - SW'(major_ff) : err_sum);
         left_in  = left_next;
         busy_in  = left_next != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         x_neg_ff   <= 1'b0;
         y_neg_ff   <= 1'b0;
         x_major_ff <= 1'b0;
         major_ff   <= '0;
         minor_ff   <= '0;
         error_ff   <= '0;
         left_ff    <= '0;
         color_ff   <= '0;
         busy_ff    <= 1'b0;
      end else begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         x_neg_ff   <= x_neg_in;
         y_neg_ff   <= y_neg_in;
         x_major_ff <= x_major_in;
         major_ff   <= major_in;
         minor_ff   <= minor_in;
         error_ff   <= error_in;
         left_ff    <= left_in;
         color_ff   <= color_in;
         busy_ff    <= busy_in;
      end
   end

   // Present the current pixel
   assign emit              = is_tick;
   assign pixel.pixel_x     = lps_pkg::FIELD_COORD_BITS'(cur_x_ff);
   assign pixel.pixel_y     = lps_pkg::FIELD_COORD_BITS'(cur_y_ff);
   assign pixel.pixel_index = lps_pkg::INDEX_BITS'(index_wide);
   assign pixel.pixel_value = color_ff;
   assign pixel.last_pixel  = left_ff == (CB + 1)'(1);

endmodule

@@ rtl/core/lps_out_reg.sv @@
`timescale 1ns / 1ps
// Result register of the line pixel stepper: holds one response transaction.
module lps_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic             emit,
   input  lps_pkg::rsp_type pixel,
   output logic             out_ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lps_pkg::rsp_type rsp_payload
);

   logic             valid_ff, valid_in;
   lps_pkg::rsp_type data_ff, data_in;

   // Free when empty or when the held transaction leaves this cycle
   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (fire) begin
         valid_in = emit;
         data_in  = pixel;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

@@ rtl/core/line_pixel_stepper.sv @@
`timescale 1ns / 1ps
// Top level of the line pixel stepper.
//
// Usage:
//   req_* carries start and tick transactions. A start loads both endpoints
//   and the colour and gives no response; each tick while a line is active
//   gives one pixel on rsp_* (column, row, framebuffer index, colour and a
//   last flag). Ticks with no active line give nothing; a start drops any
//   line in progress.
//   Timing: an accepted tick waits in the input register, then its pixel is
//   written to the result register and shown on rsp_*; rsp_stall can hold it.
//   Throughput: one transaction per cycle while rsp_stall is low, set by
//   the single pass from the input register through the stepping logic and
//   index multiply to the result register.
//   Stall: while rsp_stall holds a pixel, the input register fills and then
//   req_stall rises; nothing is lost or repeated.
//   Reset: synchronous; both registers empty, no line active, all line state zero.
module line_pixel_stepper #(
   parameter int ROW_PITCH  = lps_pkg::ROW_PITCH_DEFAULT,
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lps_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lps_pkg::rsp_type rsp_payload
);

   logic             out_ready;
   logic             item_valid;
   lps_pkg::req_type item;
   logic             fire;
   logic             emit;
   lps_pkg::rsp_type pixel;

   // Process the held transaction when the result register can take it
   assign fire = item_valid && out_ready;

   lps_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_ready   (out_ready),
      .item_valid  (item_valid),
      .item        (item)
   );

   lps_stepper #(
      .ROW_PITCH  (ROW_PITCH),
      .COORD_BITS (COORD_BITS)
   ) u_stepper (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item),
      .emit  (emit),
      .pixel (pixel)
   );

   lps_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .emit        (emit),
      .pixel       (pixel),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the line pixel stepper: directed lines, then random lines.
module tb;

   localparam int PITCH         = lps_pkg::ROW_PITCH_DEFAULT;
   localparam int CW            = lps_pkg::FIELD_COORD_BITS;
   localparam int RANDOM_ITEMS  = 900;
   localparam int DRAIN_CYCLES  = 8;

   typedef enum int {
      STALL_NONE,
      STALL_SPARSE,
      STALL_RUNS,
      STALL_HEAVY
   } stall_mode_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   lps_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   lps_pkg::rsp_type rsp_payload;

   line_pixel_stepper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Line tracer state, mirrored from the block
   logic [CW-1:0]                    trace_x      = '0;
   logic [CW-1:0]                    trace_y      = '0;
   logic                             step_x_down  = 1'b0;
   logic                             step_y_down  = 1'b0;
   logic                             x_leads      = 1'b0;
   logic [CW-1:0]                    long_span    = '0;
   logic [CW-1:0]                    short_span   = '0;
   logic [lps_pkg::ERROR_BITS-1:0]   err_acc      = '0;
   logic [CW:0]                      pixels_due   = '0;
   logic [lps_pkg::COLOR_BITS-1:0]   pen_colour   = '0;
   logic                             drawing      = 1'b0;

   lps_pkg::rsp_type pixel_queue[$];
   int      failures    = 0;
   int      items_sent  = 0;
   int      gap_max     = 4;
   int      burst_left  = 0;

   // Advance the tracer by one transaction; queue the pixel a tick gives
   task automatic trace_line(input lps_pkg::req_type item);
      logic [CW-1:0]               adx;
      logic [CW-1:0]               ady;
      int unsigned                 acc;
      lps_pkg::rsp_type            px;
      if (item.kind == lps_pkg::KIND_START) begin
         step_x_down = item.end_x < item.start_x;
         step_y_down = item.end_y < item.start_y;
         adx = step_x_down ? item.start_x - item.end_x : item.end_x - item.start_x;
         ady = step_y_down ? item.start_y - item.end_y : item.end_y - item.start_y;
         x_leads    = adx > ady;
         long_span  = x_leads ? adx : ady;
         short_span = x_leads ? ady : adx;
         err_acc    = '0;
         pixels_due = {1'b0, long_span} + (CW + 1)'(1);
         pen_colour = item.line_color;
         trace_x    = item.start_x;
         trace_y    = item.start_y;
         drawing    = 1'b1;
         items_sent++;
      end else if (drawing) begin
         px.pixel_x     = trace_x;
         px.pixel_y     = trace_y;
         px.pixel_index = lps_pkg::INDEX_BITS'(int'(trace_y) * PITCH + int'(trace_x));
         px.pixel_value = pen_colour;
         px.last_pixel  = (pixels_due == (CW + 1)'(1));
         pixel_queue.push_back(px);
         // step the major axis, then the minor one when the error overflows
         if (x_leads) trace_x = step_x_down ? trace_x - CW'(1) : trace_x + CW'(1);
         else         trace_y = step_y_down ? trace_y - CW'(1) : trace_y + CW'(1);
         acc = int'(err_acc) + int'(short_span);
         if (acc >= int'(long_span)) begin
            if (x_leads) trace_y = step_y_down ? trace_y - CW'(1) : trace_y + CW'(1);
            else         trace_x = step_x_down ? trace_x - CW'(1) : trace_x + CW'(1);
            acc = acc - int'(long_span);
         end
         err_acc    = acc[lps_pkg::ERROR_BITS-1:0];
         pixels_due = pixels_due - (CW + 1)'(1);
         drawing    = (pixels_due != '0);
         items_sent++;
      end
   endtask

   // Offer one transaction in bursts with random gaps; hold until accepted
   task automatic send_item(input lps_pkg::req_type item);
      int gap;
      @(negedge clock);
      if (gap_max > 0 && burst_left <= 0) begin
         gap = $urandom_range(1, gap_max);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trace_line(item);
   endtask

   function automatic lps_pkg::req_type start_item(input logic [8:0] sx,
                                                   input logic [8:0] sy,
                                                   input logic [8:0] ex,
                                                   input logic [8:0] ey,
                                                   input logic [15:0] colour);
      lps_pkg::req_type item;
      item.kind       = lps_pkg::KIND_START;
      item.start_x    = sx;
      item.start_y    = sy;
      item.end_x      = ex;
      item.end_y      = ey;
      item.line_color = colour;
      return item;
   endfunction

   // A tick carries random junk in the fields it does not use
   function automatic lps_pkg::req_type tick_item();
      lps_pkg::req_type item;
      item.kind       = lps_pkg::KIND_TICK;
      item.start_x    = CW'($urandom());
      item.start_y    = CW'($urandom());
      item.end_x      = CW'($urandom());
      item.end_y      = CW'($urandom());
      item.line_color = lps_pkg::COLOR_BITS'($urandom());
      return item;
   endfunction

   // Pick an endpoint within span of s, staying inside the coordinate range
   function automatic logic [8:0] near_end(input logic [8:0] s, input int span);
      int d;
      d = $urandom_range(0, span);
      if ($urandom_range(0, 1) == 1)
         return (int'(s) + d <= 511) ? s + d[8:0] : s - d[8:0];
      return (int'(s) >= d) ? s - d[8:0] : s + d[8:0];
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // Compare each accepted pixel with the oldest expected one
   always @(posedge clock) begin : check_pixels
      lps_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            $error("unexpected pixel x=0x%0h y=0x%0h", rsp_payload.pixel_x,
                   rsp_payload.pixel_y);
            failures++;
         end else begin
            want = pixel_queue.pop_front();
            check_field("pixel_x", 32'(want.pixel_x), 32'(rsp_payload.pixel_x));
            check_field("pixel_y", 32'(want.pixel_y), 32'(rsp_payload.pixel_y));
            check_field("pixel_index", 32'(want.pixel_index),
                        32'(rsp_payload.pixel_index));
            check_field("pixel_value", 32'(want.pixel_value),
                        32'(rsp_payload.pixel_value));
            check_field("last_pixel", 32'(want.last_pixel),
                        32'(rsp_payload.last_pixel));
         end
      end
   end

   // Receiver back-pressure: switch between stall modes every so often
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             run_left   = 0;

   always @(negedge clock) begin : stall_pattern
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(32, 200);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_SPARSE: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_RUNS: begin
            if (run_left == 0) begin
               rsp_stall <= ~rsp_stall;
               run_left = $urandom_range(1, 24);
            end else begin
               run_left--;
            end
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 9) < 7);
         end
      endcase
   end

   // Ticks with no line active give nothing
   task automatic test_idle_tick();
      send_item(tick_item());
      send_item(tick_item());
   endtask

   // Equal endpoints at both corners: one pixel, flagged last
   task automatic test_single_point();
      send_item(start_item(9'd0, 9'd0, 9'd0, 9'd0, 16'h0000));
      send_item(tick_item());
      send_item(tick_item());
      send_item(start_item(9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF));
      send_item(tick_item());
   endtask

   // A line ending at the x coordinate limit, so the step past the end wraps
   task automatic test_edge_wrap();
      send_item(start_item(9'd509, 9'd3, 9'd511, 9'd3, 16'hA5A5));
      repeat (4) send_item(tick_item());
   endtask

   // Equal deltas: y is the major axis, x steps down
   task automatic test_tie();
      send_item(start_item(9'd2, 9'd0, 9'd0, 9'd2, 16'h5A5A));
      repeat (3) send_item(tick_item());
   endtask

   // A start in the middle of a line drops it
   task automatic test_restart();
      send_item(start_item(9'd500, 9'd300, 9'd496, 9'd298, 16'h1234));
      repeat (2) send_item(tick_item());
      send_item(start_item(9'd7, 9'd9, 9'd8, 9'd20, 16'hEDCB));
      repeat (3) send_item(tick_item());
   endtask

   // Mostly whole short lines with random content; some long, cut or noisy
   task automatic test_random_lines();
      int               base;
      int               pick;
      int               major;
      int               minor;
      int               ticks;
      logic [8:0]       sx, sy, ex, ey;
      logic [63:0]      raw;
      lps_pkg::req_type junk;
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         pick    = $urandom_range(0, 99);
         if (pick < 5) begin
            raw  = {$urandom(), $urandom()};
            junk = raw[$bits(lps_pkg::req_type)-1:0];
            send_item(junk);
         end else begin
            sx = 9'($urandom());
            sy = 9'($urandom());
            if (pick < 8) begin
               ex = 9'($urandom());
               ey = 9'($urandom());
            end else begin
               ex = near_end(sx, 12);
               ey = near_end(sy, 12);
            end
            major = (sx > ex) ? int'(sx) - int'(ex) : int'(ex) - int'(sx);
            minor = (sy > ey) ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
            if (minor > major)
               major = minor;
            ticks = major + 1;
            if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, major);
            else if ($urandom_range(0, 99) < 20) ticks += $urandom_range(1, 2);
            send_item(start_item(sx, sy, ex, ey, 16'($urandom())));
            repeat (ticks) send_item(tick_item());
         end
      end
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_idle_tick();
      test_single_point();
      test_edge_wrap();
      test_tie();
      test_restart();
      test_random_lines();
      @(negedge clock);
      req_valid <= 1'b0;
      // drain the expected pixels, then allow for the pipeline
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pixel_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
